>>> hdl/rmrq_pkg.sv
// Package: shared constants and codes for the rotating multilevel run queue.
`default_nettype none

package rmrq_pkg;

    localparam int unsigned NUM_QUEUES_DEF  = 8;
    localparam int unsigned MAX_THREADS_DEF = 64;

    localparam int unsigned ID_W    = 6;
    localparam int unsigned CLS_W   = 3;
    localparam int unsigned QIDX_W  = 4;
    localparam int unsigned COUNT_W = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_CHOOSE = 1'b1;

    localparam logic [CLS_W-1:0] CLS_URGENT  = 3'd0;
    localparam logic [CLS_W-1:0] CLS_IO      = 3'd1;
    localparam logic [CLS_W-1:0] CLS_NORMAL  = 3'd6;
    localparam logic [CLS_W-1:0] CLS_INVALID = 3'd7;

endpackage

`default_nettype wire

>>> hdl/rmrq_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none

module rmrq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/rmrq_find.sv
// Rotating search: first non-empty queue at or after the pointer, wrapping.
`default_nettype none

module rmrq_find #(
    parameter int unsigned NUM_QUEUES = rmrq_pkg::NUM_QUEUES_DEF
) (
    input  logic [NUM_QUEUES-1:0]         mask,
    input  logic [$clog2(NUM_QUEUES)-1:0] ptr,
    output logic                          found,
    output logic [$clog2(NUM_QUEUES)-1:0] q
);

    localparam int unsigned QW = $clog2(NUM_QUEUES);
    localparam logic [QW:0] NQ_WIDE = (QW+1)'(NUM_QUEUES);

    logic [QW-1:0] idx [NUM_QUEUES];

    always_comb
    begin
        logic [QW:0] s;
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            s = {1'b0, ptr} + (QW+1)'(i);
            idx[i] = (s >= NQ_WIDE) ? QW'(s - NQ_WIDE) : s[QW-1:0];
        end
    end

    // lowest rotated position wins
    always_comb
    begin
        found = 1'b0;
        q     = '0;
        for (int i = NUM_QUEUES - 1; i >= 0; i--)
        begin
            if (mask[idx[i]])
            begin
                found = 1'b1;
                q     = idx[i];
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/rotating_multilevel_run_queue.sv
// Top level: rotating multilevel run queue scheduler.
//
//   channel   signals                                     direction
//   input     in_valid/in_ready, cmd, thread_id,          into block
//             prio_class
//   output    out_valid/out_ready, chosen_id, idle,       out of block
//             queue_index, bad_class
//
// Each item is captured in the idle state; the execute state then updates the
// queue heads/tails and accesses the link RAM, and a new item is taken only
// back in idle. A pop that leaves the queue non-empty writes the new head from
// the link RAM read data in the following cycle, which overlaps the next capture.
// Reset clears all control state; links, heads and tails are undefined until
// written. A stalled output holds the block in its execute cycle.
`default_nettype none

module rotating_multilevel_run_queue #(
    parameter int unsigned NUM_QUEUES  = rmrq_pkg::NUM_QUEUES_DEF,
    parameter int unsigned MAX_THREADS = rmrq_pkg::MAX_THREADS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        cmd,
    input  logic [rmrq_pkg::ID_W-1:0]   thread_id,
    input  logic [rmrq_pkg::CLS_W-1:0]  prio_class,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rmrq_pkg::ID_W-1:0]   chosen_id,
    output logic                        idle,
    output logic [rmrq_pkg::QIDX_W-1:0] queue_index,
    output logic                        bad_class
);

    import rmrq_pkg::*;

    localparam int unsigned QW  = $clog2(NUM_QUEUES);
    localparam int unsigned TW  = $clog2(MAX_THREADS);
    localparam int unsigned QCW = $clog2(NUM_QUEUES + 1);
    localparam logic [QCW-1:0] URGENT_CODE = QCW'(NUM_QUEUES);
    localparam logic [QW:0]    NQ_WIDE     = (QW+1)'(NUM_QUEUES);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    function automatic logic [TW-1:0] wrap_id(input logic [ID_W-1:0] v);
        int unsigned r;
        r = 32'(v);
        for (int k = ID_W - 1; k >= 0; k--)
        begin
            if (r >= (MAX_THREADS << k))
            begin
                r = r - (MAX_THREADS << k);
            end
        end
        return TW'(r);
    endfunction

    logic                  state_reg;
    logic                  cmd_reg;
    logic [TW-1:0]         id_reg;
    logic [CLS_W-1:0]      cls_reg;

    logic [TW-1:0]         head_mem [NUM_QUEUES];
    logic [TW-1:0]         tail_mem [NUM_QUEUES];
    logic [TW-1:0]         uhead_reg;
    logic [TW-1:0]         utail_reg;
    logic                  urgent_ne_reg;
    logic [NUM_QUEUES-1:0] mask_reg;
    logic [QW-1:0]         ptr_reg;
    logic [COUNT_W-1:0]    count_reg;

    logic                  pend_valid_reg;
    logic                  pend_urg_reg;
    logic [QW-1:0]         pend_q_reg;

    logic                  out_valid_reg;
    logic [ID_W-1:0]       chosen_reg;
    logic                  idle_reg;
    logic [QIDX_W-1:0]     qidx_reg;
    logic                  bad_reg;

    logic                  find_found;
    logic [QW-1:0]         find_q;
    logic [QW-1:0]         add_off;
    logic [QW:0]           add_sum;
    logic [QW-1:0]         add_q;
    logic [QW-1:0]         q_sel;
    logic [TW-1:0]         sel_head;
    logic [TW-1:0]         sel_tail;
    logic                  sel_busy;
    logic                  fire;

    logic                  ram_we;
    logic [TW-1:0]         ram_addr;
    logic [TW-1:0]         ram_wdata;
    logic [TW-1:0]         ram_rdata;

    logic                  head_set;
    logic                  tail_set;
    logic                  uhead_set;
    logic                  utail_set;
    logic                  mask_set;
    logic                  mask_clr;
    logic                  urgent_clr;
    logic                  ptr_set;
    logic                  cnt_up;
    logic                  cnt_down;
    logic                  pend_next;
    logic                  pend_urg_next;
    logic [TW-1:0]         res_chosen;
    logic                  res_idle;
    logic [QCW-1:0]        res_q;
    logic                  res_bad;
    logic [COUNT_W-1:0]    count_next;

    rmrq_find #(
        .NUM_QUEUES (NUM_QUEUES)
    ) u_find (
        .mask  (mask_reg),
        .ptr   (ptr_reg),
        .found (find_found),
        .q     (find_q)
    );

    rmrq_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_THREADS)
    ) u_link (
        .clk   (clk),
        .we    (ram_we & fire),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign fire     = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    always_comb
    begin
        unique case (cls_reg)
            CLS_IO:     add_off = '0;
            CLS_NORMAL: add_off = QW'(NUM_QUEUES - 1);
            default:    add_off = QW'(cls_reg - 3'd1);
        endcase
    end

    assign add_sum  = {1'b0, ptr_reg} + {1'b0, add_off};
    assign add_q    = (add_sum >= NQ_WIDE) ? QW'(add_sum - NQ_WIDE) : add_sum[QW-1:0];
    assign q_sel    = (cmd_reg == CMD_CHOOSE) ? find_q : add_q;
    assign sel_head = head_mem[q_sel];
    assign sel_tail = tail_mem[q_sel];
    assign sel_busy = mask_reg[q_sel];

    always_comb
    begin
        ram_we        = 1'b0;
        ram_addr      = sel_head;
        ram_wdata     = id_reg;
        head_set      = 1'b0;
        tail_set      = 1'b0;
        uhead_set     = 1'b0;
        utail_set     = 1'b0;
        mask_set      = 1'b0;
        mask_clr      = 1'b0;
        urgent_clr    = 1'b0;
        ptr_set       = 1'b0;
        cnt_up        = 1'b0;
        cnt_down      = 1'b0;
        pend_next     = 1'b0;
        pend_urg_next = 1'b0;
        res_chosen    = '0;
        res_idle      = 1'b0;
        res_q         = '0;
        res_bad       = 1'b0;
        if (cmd_reg == CMD_ADD)
        begin
            priority if (cls_reg == CLS_INVALID)
            begin
                res_bad = 1'b1;
            end
            else if (cls_reg == CLS_URGENT)
            begin
                ram_we    = urgent_ne_reg;
                ram_addr  = utail_reg;
                uhead_set = !urgent_ne_reg;
                utail_set = 1'b1;
                cnt_up    = 1'b1;
                res_q     = URGENT_CODE;
            end
            else if (cls_reg == CLS_IO)
            begin
                ram_we    = sel_busy;
                ram_addr  = id_reg;
                ram_wdata = sel_head;
                tail_set  = !sel_busy;
                head_set  = 1'b1;
                mask_set  = 1'b1;
                cnt_up    = 1'b1;
                res_q     = QCW'(add_q);
            end
            else
            begin
                ram_we    = sel_busy;
                ram_addr  = sel_tail;
                head_set  = !sel_busy;
                tail_set  = 1'b1;
                mask_set  = 1'b1;
                cnt_up    = 1'b1;
                res_q     = QCW'(add_q);
            end
        end
        else
        begin
            priority if (urgent_ne_reg)
            begin
                ram_addr   = uhead_reg;
                res_chosen = uhead_reg;
                res_q      = URGENT_CODE;
                cnt_down   = 1'b1;
                if (uhead_reg == utail_reg)
                begin
                    urgent_clr = 1'b1;
                end
                else
                begin
                    pend_next     = 1'b1;
                    pend_urg_next = 1'b1;
                end
            end
            else if (find_found)
            begin
                res_chosen = sel_head;
                res_q      = QCW'(find_q);
                ptr_set    = 1'b1;
                cnt_down   = 1'b1;
                if (sel_head == sel_tail)
                begin
                    mask_clr = 1'b1;
                end
                else
                begin
                    pend_next = 1'b1;
                end
            end
            else
            begin
                res_idle = 1'b1;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cnt_up && (count_reg != COUNT_MAX))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cnt_down && (count_reg != '0))
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // heads, tails and links: no reset
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            if (head_set)
            begin
                head_mem[q_sel] <= id_reg;
            end
            if (tail_set)
            begin
                tail_mem[q_sel] <= id_reg;
            end
            if (uhead_set)
            begin
                uhead_reg <= id_reg;
            end
            if (utail_set)
            begin
                utail_reg <= id_reg;
            end
        end
        else if (pend_valid_reg)
        begin
            if (pend_urg_reg)
            begin
                uhead_reg <= ram_rdata;
            end
            else
            begin
                head_mem[pend_q_reg] <= ram_rdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= CMD_ADD;
            id_reg         <= '0;
            cls_reg        <= CLS_URGENT;
            urgent_ne_reg  <= 1'b0;
            mask_reg       <= '0;
            ptr_reg        <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            pend_urg_reg   <= 1'b0;
            pend_q_reg     <= '0;
            out_valid_reg  <= 1'b0;
            chosen_reg     <= '0;
            idle_reg       <= 1'b0;
            qidx_reg       <= '0;
            bad_reg        <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= fire && pend_next;
            if (in_valid && in_ready)
            begin
                state_reg <= S_EXEC;
                cmd_reg   <= cmd;
                id_reg    <= wrap_id(thread_id);
                cls_reg   <= prio_class;
            end
            if (fire)
            begin
                state_reg      <= S_IDLE;
                out_valid_reg  <= 1'b1;
                chosen_reg     <= ID_W'(res_chosen);
                idle_reg       <= res_idle;
                qidx_reg       <= QIDX_W'(res_q);
                bad_reg        <= res_bad;
                count_reg      <= count_next;
                pend_urg_reg   <= pend_urg_next;
                pend_q_reg     <= q_sel;
                if (mask_set)
                begin
                    mask_reg[q_sel] <= 1'b1;
                end
                else if (mask_clr)
                begin
                    mask_reg[q_sel] <= 1'b0;
                end
                if (utail_set)
                begin
                    urgent_ne_reg <= 1'b1;
                end
                else if (urgent_clr)
                begin
                    urgent_ne_reg <= 1'b0;
                end
                if (ptr_set)
                begin
                    ptr_reg <= find_q;
                end
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign chosen_id   = chosen_reg;
    assign idle        = idle_reg;
    assign queue_index = qidx_reg;
    assign bad_class   = bad_reg;

    a_pend_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == S_IDLE))
        else $error("head writeback pending outside idle");

    a_urgent_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (cmd_reg == CMD_CHOOSE) && urgent_ne_reg) |=> $stable(ptr_reg))
        else $error("urgent pop moved rotate pointer");

    a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && idle) |-> ((chosen_id == '0) && (queue_index == '0) && !bad_class))
        else $error("idle result carries data");

    a_find_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (cmd_reg == CMD_CHOOSE) && !urgent_ne_reg && find_found)
            |-> mask_reg[find_q])
        else $error("search picked an empty queue");

endmodule

`default_nettype wire

>>> tb/sv/rotating_multilevel_run_queue_test.sv
// Testbench for the rotating multilevel run queue: directed and random add/choose traffic.
module rotating_multilevel_run_queue_test;
    import rmrq_pkg::*;

    localparam int NUM_Q       = NUM_QUEUES_DEF;
    localparam int MAX_T       = MAX_THREADS_DEF;
    localparam int PTR_W       = $clog2(NUM_Q);
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE      = 16;

    localparam logic [CLS_W-1:0]  CLS_LOCK    = 3'd2;
    localparam logic [CLS_W-1:0]  CLS_KERNEL  = 3'd3;
    localparam logic [CLS_W-1:0]  CLS_SIGNAL  = 3'd4;
    localparam logic [CLS_W-1:0]  CLS_INPUT   = 3'd5;
    localparam logic [QIDX_W-1:0] URGENT_QIDX = QIDX_W'(NUM_Q);

    typedef struct packed {
        logic [ID_W-1:0]   chosen;
        logic              idle;
        logic [QIDX_W-1:0] qidx;
        logic              bad;
    } sched_result_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              cmd;
    logic [ID_W-1:0]   thread_id;
    logic [CLS_W-1:0]  prio_class;
    logic              out_valid;
    logic              out_ready;
    logic [ID_W-1:0]   chosen_id;
    logic              idle;
    logic [QIDX_W-1:0] queue_index;
    logic              bad_class;

    rotating_multilevel_run_queue dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .thread_id   (thread_id),
        .prio_class  (prio_class),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .chosen_id   (chosen_id),
        .idle        (idle),
        .queue_index (queue_index),
        .bad_class   (bad_class)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // scheduler mirror
    logic [ID_W-1:0]  link_mem [MAX_T];
    logic [ID_W-1:0]  head_of [NUM_Q];
    logic [ID_W-1:0]  tail_of [NUM_Q];
    logic [ID_W-1:0]  urg_head;
    logic [ID_W-1:0]  urg_tail;
    logic             urg_busy = 1'b0;
    logic [NUM_Q-1:0] ring_busy = '0;
    logic [PTR_W-1:0] ring_ptr = '0;
    bit               link_known [MAX_T];
    bit               is_queued [MAX_T];
    int               links_known_count = 0;

    sched_result_t expected_decisions [$];
    sched_result_t oldest;

    int mismatch_count = 0;
    int cycle_count    = 0;
    int burst_left     = 0;
    int gap_max        = 0;
    int stall_mode     = 0;
    int stall_left     = 0;
    int add_count      = 0;
    int choose_count   = 0;
    int idle_count     = 0;
    int invalid_count  = 0;
    int urgent_pops    = 0;
    int requeue_count  = 0;
    int results_seen   = 0;

    function automatic void note_link(input logic [ID_W-1:0] at);
        if (!link_known[at])
        begin
            link_known[at] = 1'b1;
            links_known_count++;
        end
    endfunction

    function automatic sched_result_t predict_decision(input logic c,
                                                       input logic [ID_W-1:0] id,
                                                       input logic [CLS_W-1:0] cls);
        sched_result_t r;
        int unsigned   q;
        int unsigned   off;
        bit            found;
        r = '0;
        q = 0;
        found = 1'b0;
        if (c == CMD_ADD)
        begin
            if (cls == CLS_INVALID)
            begin
                r.bad = 1'b1;
                invalid_count++;
            end
            else
            begin
                if (is_queued[id])
                    requeue_count++;
                is_queued[id] = 1'b1;
                add_count++;
                if (cls == CLS_URGENT)
                begin
                    if (urg_busy)
                    begin
                        link_mem[urg_tail] = id;
                        note_link(urg_tail);
                    end
                    else
                        urg_head = id;
                    urg_tail = id;
                    urg_busy = 1'b1;
                    r.qidx = URGENT_QIDX;
                end
                else
                begin
                    if (cls == CLS_IO)
                    begin
                        q = ring_ptr;
                        if (ring_busy[q])
                        begin
                            link_mem[id] = head_of[q];
                            note_link(id);
                        end
                        else
                            tail_of[q] = id;
                        head_of[q] = id;
                    end
                    else
                    begin
                        off = (cls == CLS_NORMAL) ? NUM_Q - 1 : cls - 1;
                        q = (ring_ptr + off) % NUM_Q;
                        if (ring_busy[q])
                        begin
                            link_mem[tail_of[q]] = id;
                            note_link(tail_of[q]);
                        end
                        else
                            head_of[q] = id;
                        tail_of[q] = id;
                    end
                    ring_busy[q] = 1'b1;
                    r.qidx = QIDX_W'(q);
                end
            end
        end
        else
        begin
            choose_count++;
            if (urg_busy)
            begin
                r.chosen = urg_head;
                if (urg_head == urg_tail)
                    urg_busy = 1'b0;
                else
                    urg_head = link_mem[urg_head];
                r.qidx = URGENT_QIDX;
                urgent_pops++;
            end
            else
            begin
                for (int i = 0; i < NUM_Q; i++)
                begin
                    if (!found && ring_busy[(ring_ptr + i) % NUM_Q])
                    begin
                        found = 1'b1;
                        q = (ring_ptr + i) % NUM_Q;
                    end
                end
                if (found)
                begin
                    r.chosen = head_of[q];
                    if (head_of[q] == tail_of[q])
                        ring_busy[q] = 1'b0;
                    else
                        head_of[q] = link_mem[head_of[q]];
                    ring_ptr = PTR_W'(q);
                    r.qidx = QIDX_W'(q);
                end
                else
                begin
                    r.idle = 1'b1;
                    idle_count++;
                end
            end
            if (!r.idle)
                is_queued[r.chosen] = 1'b0;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < 20)
            $display("[%0d] mismatch: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // one transfer on the input side, with random bursts and gaps
    task automatic send_op(input logic c, input logic [ID_W-1:0] id,
                           input logic [CLS_W-1:0] cls);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        cmd        <= c;
        thread_id  <= id;
        prio_class <= cls;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_decisions.push_back(predict_decision(c, id, cls));
    endtask

    task automatic hold_input();
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (expected_decisions.size() != 0);
    endtask

    function automatic int pick_thread();
        int start;
        int cand;
        if (links_known_count == MAX_T && $urandom_range(0, 9) == 0)
            return $urandom_range(0, MAX_T - 1);
        start = $urandom_range(0, MAX_T - 1);
        for (int i = 0; i < MAX_T; i++)
        begin
            cand = (start + i) % MAX_T;
            if (!is_queued[cand])
                return cand;
        end
        return -1;
    endfunction

    task automatic random_item(input int add_pct);
        int roll;
        int id;
        roll = $urandom_range(0, 99);
        id = pick_thread();
        if (roll < 4)
            send_op(CMD_ADD, ID_W'($urandom), CLS_INVALID);
        else if (roll < add_pct && id >= 0)
            send_op(CMD_ADD, ID_W'(id), CLS_W'($urandom_range(CLS_URGENT, CLS_NORMAL)));
        else
            send_op(CMD_CHOOSE, ID_W'($urandom), CLS_W'($urandom));
    endtask

    task automatic test_empty_choose();
        send_op(CMD_CHOOSE, '1, '1);
    endtask

    task automatic test_bad_class();
        send_op(CMD_ADD, 6'd63, CLS_INVALID);
        send_op(CMD_ADD, 6'd0, CLS_INVALID);
    endtask

    task automatic test_every_class();
        send_op(CMD_ADD, 6'd0, CLS_URGENT);
        send_op(CMD_ADD, 6'd63, CLS_URGENT);
        send_op(CMD_ADD, 6'd1, CLS_IO);
        send_op(CMD_ADD, 6'd2, CLS_IO);
        send_op(CMD_ADD, 6'd3, CLS_LOCK);
        send_op(CMD_ADD, 6'd4, CLS_KERNEL);
        send_op(CMD_ADD, 6'd5, CLS_SIGNAL);
        send_op(CMD_ADD, 6'd6, CLS_INPUT);
        send_op(CMD_ADD, 6'd7, CLS_NORMAL);
        send_op(CMD_ADD, 6'd8, CLS_NORMAL);
        repeat (11)
            send_op(CMD_CHOOSE, '0, '0);
    endtask

    // pointer sits at the last queue here, so lock wraps to queue 0
    task automatic test_pointer_wrap();
        send_op(CMD_ADD, 6'd9, CLS_LOCK);
        send_op(CMD_ADD, 6'd10, CLS_NORMAL);
        send_op(CMD_CHOOSE, '0, '0);
        send_op(CMD_CHOOSE, '0, '0);
    endtask

    task automatic test_random_traffic(input int count);
        int sent;
        int seg_len;
        int add_pct;
        sent = 0;
        while (sent < count)
        begin
            seg_len = $urandom_range(40, 160);
            case ($urandom_range(0, 3))
                0:       add_pct = 25;
                1:       add_pct = 55;
                2:       add_pct = 65;
                default: add_pct = 85;
            endcase
            gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            repeat (seg_len)
            begin
                random_item(add_pct);
                sent++;
            end
        end
    endtask

    task automatic test_sender_pause();
        gap_max = 3;
        repeat (6)
        begin
            repeat ($urandom_range(3, 10))
                random_item(60);
            hold_input();
            wait_drained();
        end
    endtask

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(30, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= (stall_left % 4 == 0);
            default: out_ready <= ~out_ready;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_decisions.size() == 0)
                report_mismatch("result transfer with nothing outstanding");
            else
            begin
                oldest = expected_decisions.pop_front();
                if (chosen_id !== oldest.chosen)
                    report_mismatch($sformatf("chosen_id %0d, expected %0d",
                                              chosen_id, oldest.chosen));
                if (idle !== oldest.idle)
                    report_mismatch($sformatf("idle %0b, expected %0b", idle, oldest.idle));
                if (queue_index !== oldest.qidx)
                    report_mismatch($sformatf("queue_index %0d, expected %0d",
                                              queue_index, oldest.qidx));
                if (bad_class !== oldest.bad)
                    report_mismatch($sformatf("bad_class %0b, expected %0b",
                                              bad_class, oldest.bad));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_decisions.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        cmd        <= CMD_ADD;
        thread_id  <= '0;
        prio_class <= CLS_URGENT;
        out_ready  <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_choose();
        test_bad_class();
        test_every_class();
        test_pointer_wrap();
        test_random_traffic(900);
        test_sender_pause();
        test_random_traffic(800);

        hold_input();
        wait_drained();
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d adds (%0d requeued IDs), %0d invalid, %0d chooses",
                 add_count, requeue_count, invalid_count, choose_count);
        $display("  %0d urgent pops, %0d idle answers, %0d results checked, %0d mismatches",
                 urgent_pops, idle_count, results_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
